// ----- design/s2cd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_pkg
// Shared types and constants for the serial-to-CAN deframer.
// ----------------------------------------------------------------------------
package s2cd_pkg;

    localparam logic [7:0] HEADER_BYTE     = 8'h24;
    localparam logic [2:0] ID_HIGH_MASK    = 3'h7;
    localparam int         LEN_SHIFT       = 3;
    localparam int         MAX_FRAME_BYTES = 8;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_IDLO = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } t_in_item;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  phase;
        logic [4:0]  bytes_left;
        logic [10:0] ident;
        logic [63:0] gather_buf;
        logic [3:0]  gather_count;
    } t_state;

endpackage

// ----- design/s2cd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2cd_step
// Next-state and frame logic for one received byte.
// ----------------------------------------------------------------------------
module s2cd_step
    import s2cd_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output logic      o_emit,
    output t_out_item o_frame
);

    logic [3:0]  w_count_inc;
    logic [4:0]  w_left_dec;
    logic [63:0] w_buf_ins;

    assign w_count_inc = i_state.gather_count + 4'd1;
    assign w_left_dec  = i_state.bytes_left - 5'd1;

    // Drop the byte into the lane picked by the current fill count.
    always_comb begin
        w_buf_ins = i_state.gather_buf;
        for (int k = 0; k < MAX_FRAME_BYTES; k++) begin
            if (i_state.gather_count[2:0] == 3'(k)) begin
                w_buf_ins[8*k +: 8] = i_state.gather_buf[8*k +: 8] | i_item.rx_byte;
            end
        end
    end

    always_comb begin
        o_state            = i_state;
        o_emit             = 1'b0;
        o_frame.frame_id   = i_state.ident;
        o_frame.frame_len  = w_count_inc;
        o_frame.frame_data = w_buf_ins;
        unique case (i_state.phase)
            PH_HUNT: begin
                if (i_item.rx_byte == HEADER_BYTE) begin
                    o_state.phase = PH_LEN;
                end
            end
            PH_LEN: begin
                o_state.bytes_left = i_item.rx_byte[7:LEN_SHIFT];
                if (i_item.rx_byte[7:LEN_SHIFT] == 5'd0) begin
                    o_state.phase = PH_HUNT;
                end else begin
                    o_state.ident = {i_item.rx_byte[2:0] & ID_HIGH_MASK, 8'd0};
                    o_state.phase = PH_IDLO;
                end
            end
            PH_IDLO: begin
                o_state.ident        = i_state.ident | {3'd0, i_item.rx_byte};
                o_state.phase        = PH_DATA;
                o_state.gather_buf   = '0;
                o_state.gather_count = '0;
            end
            PH_DATA: begin
                if (i_state.bytes_left == 5'd0) begin
                    // nothing declared is left: drop the byte, back to the hunt
                    o_state.phase        = PH_HUNT;
                    o_state.gather_buf   = '0;
                    o_state.gather_count = '0;
                end else begin
                    o_state.bytes_left   = w_left_dec;
                    o_state.gather_buf   = w_buf_ins;
                    o_state.gather_count = w_count_inc;
                    if (w_left_dec == 5'd0) begin
                        o_state.phase = PH_HUNT;
                    end
                    if (w_left_dec == 5'd0 || w_count_inc >= 4'(MAX_FRAME_BYTES) ||
                        i_item.burst_end) begin
                        o_emit               = 1'b1;
                        o_state.gather_buf   = '0;
                        o_state.gather_count = '0;
                    end
                end
            end
            default: begin
                o_state.phase = PH_HUNT;
            end
        endcase
    end

endmodule

// ----- design/serial_to_can_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_to_can_deframer
// Cuts a serial byte stream into CAN frames: header hunt, length and
// identifier bytes, then payload gathered into frames of up to eight bytes.
// ----------------------------------------------------------------------------
// Path: the request that completes a frame passes the input register, then
//   the result register, before the frame shows on the output.
// Throughput: one byte per cycle; only a stalled result register holds the
//   input side, and even then the input register still takes one request.
// Reset: synchronous, active low; clears the handshake state and returns
//   the deframer to the header hunt with empty identifier and frame buffer.
// ----------------------------------------------------------------------------
module serial_to_can_deframer
    import s2cd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Input register: holds one request until the step logic consumes it.
    logic      r_in_valid;
    t_in_item  r_in_data;

    // Deframer state carried between requests.
    t_state    r_state;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out_data;

    t_state    n_state;
    logic      w_emit;
    t_out_item w_frame;
    logic      w_adv;
    logic      w_proc;
    logic      w_in_fire;

    // Advance the pipeline whenever the result register is free or draining.
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_proc     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_fire  = i_in_valid && o_in_ready;

    s2cd_step u_step (
        .i_state (r_state),
        .i_item  (r_in_data),
        .o_state (n_state),
        .o_emit  (w_emit),
        .o_frame (w_frame)
    );

    // Input stage: load on accept, drop once consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_data <= i_in_data;
        end
    end

    // State update: one request consumed per advancing cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_proc) begin
            r_state <= n_state;
        end
    end

    // Result stage: capture a finished frame, hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_proc && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_emit) begin
            r_out_data <= w_frame;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A held frame always carries between one and eight bytes.
    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.frame_len != 4'd0 &&
                         o_out_data.frame_len <= 4'(MAX_FRAME_BYTES)))
        else $error("frame length out of range");

    // Payload phase is only entered with bytes still declared.
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_DATA |-> r_state.bytes_left != 5'd0)
        else $error("payload phase with no bytes left");

    // A full buffer is always flushed in the same step.
    a_gather_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.gather_count < 4'(MAX_FRAME_BYTES))
        else $error("gather count overflow");

    // In the hunt and length phases no bytes are gathered.
    a_idle_buf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_HUNT || r_state.phase == PH_LEN) |->
            r_state.gather_count == 4'd0)
        else $error("bytes held outside payload phase");

    // Reset returns to the header hunt.
    a_reset_hunt: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state.phase == PH_HUNT && !r_out_valid))
        else $error("reset did not return to hunt");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial-to-CAN deframer. Serial bytes go in
// through the request channel: framed packets with random identifiers,
// lengths and burst ends, mixed with line noise and stray headers. A
// behavioral deframer inside the scoreboard predicts every CAN frame, and
// each frame that leaves the block is compared field by field with the
// oldest prediction. Both channels idle in random bursts; the tail of the
// run streams at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import s2cd_pkg::*;

    // Tracks the deframer state and holds the frames still owed by the block.
    class frame_scoreboard;
        logic [1:0]  phase;
        logic [4:0]  bytes_left;
        logic [10:0] ident;
        logic [63:0] gather_buf;
        logic [3:0]  gather_count;
        t_out_item   expected_frames[$];
        int          errors;

        function new();
            phase        = PH_HUNT;
            bytes_left   = '0;
            ident        = '0;
            gather_buf   = '0;
            gather_count = '0;
            errors       = 0;
        endfunction

        // Advance the deframer by one accepted request.
        function void note_request(t_in_item req);
            t_out_item frame;
            case (phase)
                PH_HUNT: begin
                    if (req.rx_byte == HEADER_BYTE) phase = PH_LEN;
                end
                PH_LEN: begin
                    bytes_left = req.rx_byte[7:LEN_SHIFT];
                    if (bytes_left == 0) begin
                        phase = PH_HUNT;
                    end else begin
                        ident = {req.rx_byte[2:0] & ID_HIGH_MASK, 8'h00};
                        phase = PH_IDLO;
                    end
                end
                PH_IDLO: begin
                    ident        = ident | {3'b000, req.rx_byte};
                    phase        = PH_DATA;
                    gather_buf   = '0;
                    gather_count = '0;
                end
                default: begin
                    if (bytes_left == 0) begin
                        // cannot happen; drop the byte and rehunt
                        phase        = PH_HUNT;
                        gather_buf   = '0;
                        gather_count = '0;
                    end else begin
                        gather_buf   = gather_buf |
                                       ({56'h0, req.rx_byte} << (8 * gather_count[2:0]));
                        gather_count = gather_count + 4'd1;
                        bytes_left   = bytes_left - 5'd1;
                        if (bytes_left == 0) phase = PH_HUNT;
                        if (bytes_left == 0 || gather_count >= MAX_FRAME_BYTES ||
                            req.burst_end) begin
                            frame.frame_id   = ident;
                            frame.frame_len  = gather_count;
                            frame.frame_data = gather_buf;
                            expected_frames.push_back(frame);
                            gather_buf   = '0;
                            gather_count = '0;
                        end
                    end
                end
            endcase
        endfunction

        // Compare one emitted frame with the oldest prediction.
        function void check_frame(t_out_item got);
            t_out_item exp_frame;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected frame id=%h len=%0d data=%h",
                         $time, got.frame_id, got.frame_len, got.frame_data);
                errors++;
                return;
            end
            exp_frame = expected_frames.pop_front();
            if (got.frame_id !== exp_frame.frame_id) begin
                $display("%0t: frame_id mismatch: expected %h, actual %h",
                         $time, exp_frame.frame_id, got.frame_id);
                errors++;
            end
            if (got.frame_len !== exp_frame.frame_len) begin
                $display("%0t: frame_len mismatch: expected %0d, actual %0d",
                         $time, exp_frame.frame_len, got.frame_len);
                errors++;
            end
            if (got.frame_data !== exp_frame.frame_data) begin
                $display("%0t: frame_data mismatch: expected %h, actual %h",
                         $time, exp_frame.frame_data, got.frame_data);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_data    = '0;
    logic      out_ready  = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    frame_scoreboard sb;

    // Idle shaping: percent chance of a gap before each request, and the
    // full-rate tail where neither side idles.
    int unsigned gap_pct   = 0;
    bit          calm      = 1'b0;
    int          ready_run = 0;

    serial_to_can_deframer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Drive one request at the falling edge, optionally after a random gap,
    // and hold it until the block takes it. Valid stays high on return so
    // back-to-back requests stream without a bubble.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{rx_byte: b, burst_end: last};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(in_data);
    endtask

    // Result side backpressure: random runs of ready (mostly) and stall;
    // hold ready high once the tail of the run starts.
    always @(negedge i_clk) begin
        if (ready_run == 0) begin
            if (calm) begin
                out_ready <= 1'b1;
                ready_run = 1;
            end else begin
                out_ready <= ($urandom_range(3) != 0);
                ready_run = $urandom_range(1, 15);
            end
        end
        ready_run = ready_run - 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_frame(o_out_data);
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int          counted;
        int unsigned len;
        int unsigned roll;
        int unsigned noise_cnt;
        logic [10:0] pkt_id;

        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise while hunting (burst end ignored), zero length,
        // shortest frame at the top identifier with burst ends on the
        // header bytes, then a ten-byte packet split by a full frame, a
        // burst end and the end of the declared length.
        gap_pct = 20;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(HEADER_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(HEADER_BYTE, 1'b1);
        send_byte({5'd1, 3'b111}, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(HEADER_BYTE, 1'b0);
        send_byte({5'd10, 3'b010}, 1'b0);
        send_byte(8'h5A, 1'b0);
        for (int k = 0; k < 8; k++) send_byte(8'h11 * k[7:0], 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);

        // Random: mostly well-formed packets with random content, some
        // line noise and stray headers in between.
        counted = 0;
        while (counted < 1700) begin
            calm = (counted >= 1450);
            if ($urandom_range(15) == 0) begin
                case ($urandom_range(3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    2:       gap_pct = 30;
                    default: gap_pct = 60;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 18) begin
                noise_cnt = $urandom_range(1, 6);
                repeat (noise_cnt)
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                counted += noise_cnt;
            end else if (roll < 22) begin
                // stray header straight into noise
                send_byte(HEADER_BYTE, 1'b0);
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                counted += 2;
            end else begin
                roll = $urandom_range(99);
                if (roll < 5)       len = 0;
                else if (roll < 20) len = $urandom_range(13, 31);
                else                len = $urandom_range(1, 12);
                pkt_id = 11'($urandom_range(2047));
                send_byte(HEADER_BYTE, ($urandom_range(9) == 0));
                send_byte({len[4:0], pkt_id[10:8]}, ($urandom_range(9) == 0));
                counted += 2;
                if (len != 0) begin
                    send_byte(pkt_id[7:0], ($urandom_range(9) == 0));
                    counted += 1;
                    for (int k = 0; k < len; k++) begin
                        send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
                    end
                    counted += len;
                end
            end
        end

        @(negedge i_clk);
        in_valid <= 1'b0;

        // Drain outstanding frames, then let the pipeline settle.
        while (sb.expected_frames.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
